// ----- hw/rtl/kvbam_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvbam_pkg
// Shared types and constants for the key/value block address map.
// ----------------------------------------------------------------------------
package kvbam_pkg;

    localparam int unsigned BLOCK_BYTES = 4096;
    localparam int unsigned MAX_FILES   = 64;
    localparam int unsigned DIV_W       = 32;

    typedef enum logic [2:0] {
        REG_MODE   = 3'd0,
        REG_STRIPE = 3'd1,
        REG_FILES  = 3'd2,
        REG_BPF    = 3'd3,
        REG_HLS    = 3'd4,
        REG_FLS    = 3'd5,
        REG_HHS    = 3'd6,
        REG_FHS    = 3'd7
    } t_reg;

    typedef struct packed {
        logic [31:0] host_block;
        logic [7:0]  layer;
        logic        value_half;
        logic [31:0] q1;
        logic [31:0] r1;
    } t_side;

endpackage

// ----- hw/rtl/kvbam_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvbam_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module kvbam_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [31:0]            i_dividend,
    input  logic [31:0]            i_divisor,
    input  kvbam_pkg::t_side       i_side,
    output logic                   o_valid,
    output logic [31:0]            o_quo,
    output logic [31:0]            o_rem,
    output kvbam_pkg::t_side       o_side
);
    import kvbam_pkg::*;

    logic [DIV_W-1:0] r_rem  [0:DIV_W];
    logic [DIV_W-1:0] r_q    [0:DIV_W];
    logic [DIV_W-1:0] r_d    [0:DIV_W];
    t_side            r_side [0:DIV_W];
    logic             r_vld  [0:DIV_W];

    always_comb begin
        r_rem[0]  = '0;
        r_q[0]    = i_dividend;
        r_d[0]    = i_divisor;
        r_side[0] = i_side;
        r_vld[0]  = i_valid;
    end

    for (genvar k = 0; k < DIV_W; k++) begin : g_stage
        logic [DIV_W:0]   n_trial;
        logic             n_ge;
        logic [DIV_W-1:0] n_rem;

        always_comb begin
            n_trial = {r_rem[k], r_q[k][DIV_W-1]};
            n_ge    = (n_trial >= {1'b0, r_d[k]});
            n_rem   = n_ge ? DIV_W'(n_trial - {1'b0, r_d[k]}) : n_trial[DIV_W-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
            if (i_en) begin
                r_rem[k+1]  <= n_rem;
                r_q[k+1]    <= {r_q[k][DIV_W-2:0], n_ge};
                r_d[k+1]    <= r_d[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_vld[DIV_W];
    assign o_quo   = r_q[DIV_W];
    assign o_rem   = r_rem[DIV_W];
    assign o_side  = r_side[DIV_W];

endmodule

// ----- hw/rtl/kv_block_address_map.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kv_block_address_map
// Maps a storage block to file and block-in-file, and computes file and
// host byte offsets for one key/value block transfer.
// Pipeline: 68 register stages, two 32-stage dividers, then four arithmetic
// and output stages.
// Throughput: one transfer per cycle; the whole pipeline holds while the
// output register is full and not taken.
// Reset: synchronous, clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module kv_block_address_map (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_host_block,
    input  logic [31:0] i_store_block,
    input  logic [7:0]  i_layer,
    input  logic        i_value_half,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_file_index,
    output logic [31:0] o_block_in_file,
    output logic [63:0] o_file_offset,
    output logic [63:0] o_host_offset,
    output logic        o_out_of_range,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import kvbam_pkg::*;

    logic        r_mode;
    logic [15:0] r_stripe;
    logic [6:0]  r_files;
    logic [31:0] r_bpf;
    logic [47:0] r_hls, r_fls, r_hhs, r_fhs;

    logic        en;
    logic [15:0] stripe_eff;
    logic [6:0]  files_eff;
    logic [31:0] bpf_eff;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 1'b1;
            r_stripe <= 16'd1;
            r_files  <= 7'd1;
            r_bpf    <= 32'd1;
            r_hls    <= '0;
            r_fls    <= '0;
            r_hhs    <= '0;
            r_fhs    <= '0;
        end else if (i_cfg_valid) begin
            case (t_reg'(i_cfg_index))
                REG_MODE:   r_mode   <= i_cfg_data[0];
                REG_STRIPE: r_stripe <= i_cfg_data[15:0];
                REG_FILES:  r_files  <= i_cfg_data[6:0];
                REG_BPF:    r_bpf    <= i_cfg_data[31:0];
                REG_HLS:    r_hls    <= i_cfg_data[47:0];
                REG_FLS:    r_fls    <= i_cfg_data[47:0];
                REG_HHS:    r_hhs    <= i_cfg_data[47:0];
                REG_FHS:    r_fhs    <= i_cfg_data[47:0];
                default:    r_mode   <= r_mode;
            endcase
        end
    end

    always_comb begin
        stripe_eff = (r_stripe == '0) ? 16'd1 : r_stripe;
        bpf_eff    = (r_bpf == '0) ? 32'd1 : r_bpf;
        if (r_files == '0) begin
            files_eff = 7'd1;
        end else if (r_files > 7'(MAX_FILES)) begin
            files_eff = 7'(MAX_FILES);
        end else begin
            files_eff = r_files;
        end
    end

    // global hold while the output register is full and not taken
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    t_side s_in, d1_side, d2_side;
    logic  d1_vld, d2_vld;
    logic [31:0] d1_q, d1_r, d2_q, d2_r;
    t_side s_mid;

    always_comb begin
        s_in.host_block = i_host_block;
        s_in.layer      = i_layer;
        s_in.value_half = i_value_half;
        s_in.q1         = '0;
        s_in.r1         = '0;
    end

    kvbam_div u_div1 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_in_valid && en),
        .i_dividend (i_store_block),
        .i_divisor  (r_mode ? bpf_eff : {16'd0, stripe_eff}),
        .i_side     (s_in),
        .o_valid    (d1_vld),
        .o_quo      (d1_q),
        .o_rem      (d1_r),
        .o_side     (d1_side)
    );

    always_comb begin
        s_mid    = d1_side;
        s_mid.q1 = d1_q;
        s_mid.r1 = d1_r;
    end

    kvbam_div u_div2 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (d1_vld),
        .i_dividend (d1_q),
        .i_divisor  ({25'd0, files_eff}),
        .i_side     (s_mid),
        .o_valid    (d2_vld),
        .o_quo      (d2_q),
        .o_rem      (d2_r),
        .o_side     (d2_side)
    );

    // stage A: products and file selection
    logic        r_a_vld, r_a_vh, r_a_oor;
    logic [5:0]  r_a_fidx;
    logic [47:0] r_a_prod;
    logic [31:0] r_a_r1;
    logic [55:0] r_a_lf, r_a_lh;
    logic [63:0] r_a_hb;
    logic        n_a_oor;
    logic [5:0]  n_a_fidx;

    always_comb begin
        if (r_mode) begin
            n_a_oor  = (d2_side.q1 >= {25'd0, files_eff});
            n_a_fidx = n_a_oor ? 6'd0 : d2_side.q1[5:0];
        end else begin
            n_a_oor  = 1'b0;
            n_a_fidx = d2_r[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= d2_vld;
        end
        if (en) begin
            r_a_vh   <= d2_side.value_half;
            r_a_oor  <= n_a_oor;
            r_a_fidx <= n_a_fidx;
            r_a_prod <= r_mode ? 48'd0 : d2_q * stripe_eff;
            r_a_r1   <= d2_side.r1;
            r_a_lf   <= d2_side.layer * r_fls;
            r_a_lh   <= d2_side.layer * r_hls;
            r_a_hb   <= {32'd0, d2_side.host_block} * 64'(BLOCK_BYTES);
        end
    end

    // stage B: block in file, host offset
    logic        r_b_vld, r_b_vh, r_b_oor;
    logic [5:0]  r_b_fidx;
    logic [31:0] r_b_bif;
    logic [55:0] r_b_lf;
    logic [63:0] r_b_hoff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_a_vld;
        end
        if (en) begin
            r_b_vh   <= r_a_vh;
            r_b_oor  <= r_a_oor;
            r_b_fidx <= r_a_fidx;
            r_b_bif  <= 32'(r_a_prod + {16'd0, r_a_r1});
            r_b_lf   <= r_a_lf;
            r_b_hoff <= {8'd0, r_a_lh} + r_a_hb
                        + (r_a_vh ? {16'd0, r_hhs} : 64'd0);
        end
    end

    // stage C: block byte product
    logic        r_c_vld, r_c_vh, r_c_oor;
    logic [5:0]  r_c_fidx;
    logic [31:0] r_c_bif;
    logic [55:0] r_c_lf;
    logic [63:0] r_c_hoff, r_c_fb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= r_b_vld;
        end
        if (en) begin
            r_c_vh   <= r_b_vh;
            r_c_oor  <= r_b_oor;
            r_c_fidx <= r_b_fidx;
            r_c_bif  <= r_b_bif;
            r_c_lf   <= r_b_lf;
            r_c_hoff <= r_b_hoff;
            r_c_fb   <= {32'd0, r_b_bif} * 64'(BLOCK_BYTES);
        end
    end

    // stage D: file offset and output register
    logic        r_out_vld, r_out_oor;
    logic [5:0]  r_out_fidx;
    logic [31:0] r_out_bif;
    logic [63:0] r_out_foff, r_out_hoff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_c_vld;
        end
        if (en) begin
            r_out_oor  <= r_c_oor;
            r_out_fidx <= r_c_fidx;
            r_out_bif  <= r_c_bif;
            r_out_hoff <= r_c_hoff;
            r_out_foff <= {8'd0, r_c_lf} + r_c_fb
                          + (r_c_vh ? {16'd0, r_fhs} : 64'd0);
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_file_index    = r_out_fidx;
    assign o_block_in_file = r_out_bif;
    assign o_file_offset   = r_out_foff;
    assign o_host_offset   = r_out_hoff;
    assign o_out_of_range  = r_out_oor;

    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_of_range |-> o_file_index == 6'd0)
        else $error("out of range result with nonzero file index");

    a_stripe_no_oor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !r_mode |-> !o_out_of_range)
        else $error("out of range flagged in striped mode");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

// ----- sim/tb_kv_block_address_map.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kv_block_address_map
// Drives block transfers with random gaps and output stalls, predicts the
// file and host addresses of each transfer, and checks every output field.
// ----------------------------------------------------------------------------
module tb_kv_block_address_map;
    import kvbam_pkg::*;

    typedef struct {
        logic [31:0] host_block;
        logic [31:0] store_block;
        logic [7:0]  layer;
        logic        value_half;
    } t_xfer;

    typedef struct {
        logic [5:0]  file_index;
        logic [31:0] block_in_file;
        logic [63:0] file_offset;
        logic [63:0] host_offset;
        logic        out_of_range;
    } t_addr;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_host_block = '0;
    logic [31:0] i_store_block = '0;
    logic [7:0]  i_layer = '0;
    logic        i_value_half = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [5:0]  o_file_index;
    logic [31:0] o_block_in_file;
    logic [63:0] o_file_offset;
    logic [63:0] o_host_offset;
    logic        o_out_of_range;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    localparam int LATENCY = 68;

    kv_block_address_map DUT (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    logic        cf_mode;
    logic [15:0] cf_stripe;
    logic [6:0]  cf_files;
    logic [31:0] cf_bpf;
    logic [47:0] cf_hls, cf_fls, cf_hhs, cf_fhs;

    t_xfer pending_xfers[$];
    t_addr expected_addrs[$];
    int    mismatches = 0;
    int    in_gap = 0;
    int    out_gap = 0;
    bit    hold_req = 1'b0;
    bit    hold_on = 1'b0;
    longint cycles = 0;

    // accepted flags captured at the rising edge
    logic o_in_ready_q = 1'b0;
    logic o_out_valid_q = 1'b0;

    function automatic t_addr map_block(t_xfer x);
        t_addr   a;
        longint unsigned files, bpf, stripe, unit, fidx, bif;
        files = (cf_files == 0) ? 1 : cf_files;
        if (files > MAX_FILES) files = MAX_FILES;
        a.out_of_range = 1'b0;
        if (cf_mode) begin
            bpf  = (cf_bpf == 0) ? 1 : cf_bpf;
            fidx = x.store_block / bpf;
            bif  = x.store_block % bpf;
            if (fidx >= files) begin
                a.out_of_range = 1'b1;
                fidx = 0;
            end
        end else begin
            stripe = (cf_stripe == 0) ? 1 : cf_stripe;
            unit   = x.store_block / stripe;
            fidx   = unit % files;
            bif    = (unit / files) * stripe + x.store_block % stripe;
        end
        a.file_index    = fidx[5:0];
        a.block_in_file = bif[31:0];
        a.file_offset   = 64'(x.layer) * 64'(cf_fls) + bif * BLOCK_BYTES
                          + (x.value_half ? 64'(cf_fhs) : 64'd0);
        a.host_offset   = 64'(x.layer) * 64'(cf_hls) + 64'(x.host_block) * BLOCK_BYTES
                          + (x.value_half ? 64'(cf_hhs) : 64'd0);
        return a;
    endfunction

    function automatic void queue_xfer(t_xfer x);
        pending_xfers = {pending_xfers, x};
    endfunction

    task automatic write_reg(t_reg idx, logic [63:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_MODE:   cf_mode   = data[0];
            REG_STRIPE: cf_stripe = data[15:0];
            REG_FILES:  cf_files  = data[6:0];
            REG_BPF:    cf_bpf    = data[31:0];
            REG_HLS:    cf_hls    = data[47:0];
            REG_FLS:    cf_fls    = data[47:0];
            REG_HHS:    cf_hhs    = data[47:0];
            REG_FHS:    cf_fhs    = data[47:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic configure(logic mode, logic [15:0] stripe, logic [6:0] files,
                             logic [31:0] bpf, logic [47:0] hls, logic [47:0] fls,
                             logic [47:0] hhs, logic [47:0] fhs);
        write_reg(REG_MODE, {$urandom, $urandom} & ~64'h1 | 64'(mode));
        write_reg(REG_STRIPE, ({$urandom, $urandom} & ~64'hFFFF) | 64'(stripe));
        write_reg(REG_FILES, ({$urandom, $urandom} & ~64'h7F) | 64'(files));
        write_reg(REG_BPF, {$urandom, 32'h0} | 64'(bpf));
        write_reg(REG_HLS, ({$urandom, $urandom} & ~64'hFFFF_FFFF_FFFF) | 64'(hls));
        write_reg(REG_FLS, ({$urandom, $urandom} & ~64'hFFFF_FFFF_FFFF) | 64'(fls));
        write_reg(REG_HHS, ({$urandom, $urandom} & ~64'hFFFF_FFFF_FFFF) | 64'(hhs));
        write_reg(REG_FHS, ({$urandom, $urandom} & ~64'hFFFF_FFFF_FFFF) | 64'(fhs));
    endtask

    task automatic wait_drained();
        while (pending_xfers.size() != 0 || i_in_valid || expected_addrs.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    function automatic t_xfer rand_xfer();
        t_xfer x;
        x.host_block  = $urandom;
        x.layer       = 8'($urandom);
        x.value_half  = 1'($urandom);
        case ($urandom_range(0, 3))
            0: x.store_block = $urandom;
            1: x.store_block = $urandom_range(0, 255);
            2: x.store_block = $urandom_range(0, 65535);
            default: x.store_block = cf_mode
                ? 32'(64'(cf_bpf) * $urandom_range(0, 70) + $urandom_range(0, 3) - 1)
                : $urandom_range(0, 4095);
        endcase
        return x;
    endfunction

    function automatic t_xfer mk(logic [31:0] hb, logic [31:0] sb, logic [7:0] ly,
                                 logic vh);
        t_xfer x;
        x.host_block = hb; x.store_block = sb; x.layer = ly; x.value_half = vh;
        return x;
    endfunction

    task automatic random_phase(int n);
        repeat (n) queue_xfer(rand_xfer());
        wait_drained();
    endtask

    // long receiver stall
    initial begin
        wait (hold_req);
        hold_on = 1'b1;
        repeat (2000) @(posedge i_clk);
        hold_on = 1'b0;
    end

    // driver
    always @(negedge i_clk) begin : p_drive
        t_xfer x;
        int    gap;
        logic  load;
        load = 1'b0;
        if (i_in_valid && o_in_ready_q) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (gap == 0 && pending_xfers.size() != 0) begin
                load = 1'b1;
            end else begin
                in_gap <= (gap == 0) ? 0 : gap - 1;
            end
        end else if (!i_in_valid && i_rst_n && pending_xfers.size() != 0) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
            end else begin
                load = 1'b1;
            end
        end
        if (load) begin
            x = pending_xfers.pop_front();
            i_host_block  <= x.host_block;
            i_store_block <= x.store_block;
            i_layer       <= x.layer;
            i_value_half  <= x.value_half;
            i_in_valid    <= 1'b1;
            expected_addrs = {expected_addrs, map_block(x)};
        end else if (i_in_valid && o_in_ready_q) begin
            i_in_valid <= 1'b0;
        end
        if (hold_on) begin
            i_out_ready <= 1'b0;
        end else if (i_out_ready && o_out_valid_q) begin
            out_gap     <= $urandom_range(0, 18);
            i_out_ready <= ($urandom_range(0, 2) == 0);
        end else if (out_gap > 0) begin
            out_gap     <= out_gap - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cycles        <= cycles + 1;
        o_in_ready_q  <= i_in_valid && o_in_ready;
        o_out_valid_q <= o_out_valid && i_out_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_addrs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected output at cycle %0d", cycles);
            end else begin
                t_addr e;
                e = expected_addrs.pop_front();
                if (e.file_index !== o_file_index || e.block_in_file !== o_block_in_file
                    || e.file_offset !== o_file_offset || e.host_offset !== o_host_offset
                    || e.out_of_range !== o_out_of_range) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d %h %h %h %b act %0d %h %h %h %b",
                                 e.file_index, e.block_in_file, e.file_offset,
                                 e.host_offset, e.out_of_range, o_file_index,
                                 o_block_in_file, o_file_offset, o_host_offset,
                                 o_out_of_range);
                end
            end
        end
        if (cycles > 2000000) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        cf_mode = 1'b1; cf_stripe = 16'd1; cf_files = 7'd1; cf_bpf = 32'd1;
        cf_hls = '0; cf_fls = '0; cf_hhs = '0; cf_fhs = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset defaults: only block zero maps in range
        queue_xfer(mk(32'd0, 32'd0, 8'd0, 1'b0));
        queue_xfer(mk(32'hFFFF_FFFF, 32'd1, 8'hFF, 1'b1));
        wait_drained();

        configure(1'b1, 16'd1, 7'd4, 32'd10, 48'h1000, 48'h2000, 48'h80, 48'h40);
        queue_xfer(mk(32'd0, 32'd0, 8'd0, 1'b0));
        queue_xfer(mk(32'd5, 32'd39, 8'd3, 1'b1));
        queue_xfer(mk(32'd5, 32'd40, 8'd3, 1'b1));
        queue_xfer(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1));
        wait_drained();

        // zero divisors and too many files
        configure(1'b0, 16'd0, 7'd0, 32'd0, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                  48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        queue_xfer(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1));
        queue_xfer(mk(32'd1, 32'd7, 8'd1, 1'b0));
        wait_drained();
        configure(1'b1, 16'd0, 7'd127, 32'd0, 48'd0, 48'd1, 48'd2, 48'd3);
        queue_xfer(mk(32'd2, 32'd63, 8'd0, 1'b1));
        queue_xfer(mk(32'd2, 32'd64, 8'd0, 1'b1));
        queue_xfer(mk(32'd2, 32'hFFFF_FFFF, 8'd9, 1'b0));
        wait_drained();
        configure(1'b0, 16'hFFFF, 7'd64, 32'hFFFF_FFFF, 48'h12345, 48'h777, 48'h1, 48'h10);
        queue_xfer(mk(32'd0, 32'hFFFF_FFFF, 8'd0, 1'b0));
        queue_xfer(mk(32'd0, 32'd65535, 8'd1, 1'b1));
        queue_xfer(mk(32'd0, 32'd65536, 8'd2, 1'b0));
        wait_drained();
        configure(1'b1, 16'd3, 7'd64, 32'hFFFF_FFFF, 48'd5, 48'd6, 48'd7, 48'd8);
        queue_xfer(mk(32'd0, 32'hFFFF_FFFE, 8'd0, 1'b1));
        queue_xfer(mk(32'd0, 32'hFFFF_FFFF, 8'd0, 1'b0));
        wait_drained();

        // long output stall while the input keeps offering transfers
        configure(1'b0, 16'd4, 7'd5, 32'd7, 48'h100, 48'h200, 48'h300, 48'h400);
        @(negedge i_clk);
        hold_req = 1'b1;
        random_phase(150);

        for (int ph = 0; ph < 8; ph++) begin
            configure(1'($urandom_range(0, 1)),
                      ($urandom_range(0, 3) == 0) ? 16'($urandom)
                      : 16'($urandom_range(1, 16)),
                      7'($urandom_range(0, 127)),
                      ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 300),
                      48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                      48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
            random_phase(145);
        end
        if (mismatches == 0 && expected_addrs.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
